// ----- rtl/rv32_pkg.sv -----
// ----------------------------------------------------------------------------
// rv32_pkg
// Shared types and constants for the RV32IM executor.
// ----------------------------------------------------------------------------
package rv32_pkg;

	localparam logic [6:0] OPC_LOAD   = 7'd3;
	localparam logic [6:0] OPC_OPIMM  = 7'd19;
	localparam logic [6:0] OPC_AUIPC  = 7'd23;
	localparam logic [6:0] OPC_STORE  = 7'd35;
	localparam logic [6:0] OPC_OP     = 7'd51;
	localparam logic [6:0] OPC_LUI    = 7'd55;
	localparam logic [6:0] OPC_BRANCH = 7'd99;
	localparam logic [6:0] OPC_JALR   = 7'd103;
	localparam logic [6:0] OPC_JAL    = 7'd111;
	localparam logic [6:0] OPC_SYSTEM = 7'd115;

	localparam logic [31:0] SVC_GETC = 32'd1;
	localparam logic [31:0] SVC_PUTC = 32'd2;
	localparam logic [31:0] SVC_EXIT = 32'd3;
	localparam logic [31:0] SVC_HALT = 32'd93;

	localparam logic [1:0] MODE_INSTR = 2'd0;
	localparam logic [1:0] MODE_LOAD  = 2'd1;
	localparam logic [1:0] MODE_CHAR  = 2'd2;

	localparam logic [1:0] MEM_NONE  = 2'd0;
	localparam logic [1:0] MEM_READ  = 2'd1;
	localparam logic [1:0] MEM_WRITE = 2'd2;

	localparam logic [1:0] CON_NONE = 2'd0;
	localparam logic [1:0] CON_REQ  = 2'd1;
	localparam logic [1:0] CON_OUT  = 2'd2;
	localparam logic [1:0] CON_HALT = 2'd3;

	localparam int QDEPTH = 2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] instruction_word;
		logic [31:0] load_value;
		logic [8:0]  console_char;
	} word_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic [1:0]  mem_op;
		logic [1:0]  mem_size;
		logic [31:0] mem_address;
		logic [31:0] store_value;
		logic [1:0]  console_op;
		logic [7:0]  console_out;
		logic [31:0] retired_count;
	} result_t;

	// front-end classification
	typedef struct packed {
		logic        is_mdu;
		logic        is_div;
		logic        div_signed;
		logic        div_rem;
	} cls_t;

	typedef struct packed {
		word_t w;
		cls_t  c;
	} qent_t;

endpackage

// ----- rtl/rv32_front.sv -----
// ----------------------------------------------------------------------------
// rv32_front
// Accepts words, classifies them and buffers them in a short queue.
// ----------------------------------------------------------------------------
module rv32_front import rv32_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_stall,
	input  word_t  in_word,
	output logic   q_valid,
	input  logic   q_pop,
	output qent_t  q_head
);

	qent_t                 mem_q [QDEPTH];
	logic                  wp_q, rp_q;
	logic [1:0]            cnt_q;
	cls_t                  c;
	logic                  push;

	always_comb begin
		c.is_mdu     = in_word.mode == MODE_INSTR &&
			in_word.instruction_word[6:0] == OPC_OP &&
			in_word.instruction_word[31:25] == 7'd1;
		c.is_div     = c.is_mdu && in_word.instruction_word[14];
		c.div_signed = !in_word.instruction_word[12];
		c.div_rem    = in_word.instruction_word[13];
	end

	assign in_stall = cnt_q == 2'(QDEPTH);
	assign push     = in_valid && !in_stall;
	assign q_valid  = cnt_q != 2'd0;
	assign q_head   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= '{w: in_word, c: c};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (q_pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

// ----- rtl/rv32_div.sv -----
// ----------------------------------------------------------------------------
// rv32_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rv32_div import rv32_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        sgn,
	input  logic        rem,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [31:0] result
);

	logic [31:0] q_q, r_q, d_q, a_q, b_q;
	logic [5:0]  cnt_q;
	logic        busy_q, sgn_q, rem_q, neg_q, rneg_q;
	logic [33:0] trial;
	logic [32:0] rsh;
	logic [31:0] qf, rf;

	assign rsh   = {r_q, q_q[31]};
	assign trial = {1'b0, rsh} - {2'b00, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			b_q    <= b;
			sgn_q  <= sgn;
			rem_q  <= rem;
			neg_q  <= sgn && (a[31] ^ b[31]);
			rneg_q <= sgn && a[31];
			q_q    <= (sgn && a[31]) ? 32'd0 - a : a;
			d_q    <= (sgn && b[31]) ? 32'd0 - b : b;
			r_q    <= '0;
		end else if (busy_q) begin
			if (!trial[33]) begin
				r_q <= trial[31:0];
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= rsh[31:0];
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end

	assign qf = neg_q ? 32'd0 - q_q : q_q;
	assign rf = rneg_q ? 32'd0 - r_q : r_q;

	always_comb begin
		if (b_q == 32'd0) begin
			result = rem_q ? a_q : 32'hFFFF_FFFF;
		end else if (sgn_q && a_q == 32'h8000_0000 && b_q == 32'hFFFF_FFFF) begin
			result = rem_q ? 32'd0 : a_q;
		end else begin
			result = rem_q ? rf : qf;
		end
	end

endmodule

// ----- rtl/rv32_back.sv -----
// ----------------------------------------------------------------------------
// rv32_back
// Executes queued words against the architectural state.
// ----------------------------------------------------------------------------
module rv32_back import rv32_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_pc,
	input  logic        q_valid,
	output logic        q_pop,
	input  qent_t       q_head,
	output logic        out_valid,
	input  logic        out_stall,
	output result_t     out_res
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_DIV  = 4'b1000
	} state_t;

	state_t      state_q;
	logic [31:0] rf_q [32];
	logic [31:0] pc_q, cnt_q;
	logic        halted_q, wcon_q;
	logic [4:0]  ldest_q;
	logic [2:0]  lkind_q;
	qent_t       e_q;
	logic [31:0] a_q, b_q;
	logic [63:0] prod_q;
	logic        div_start, div_done;
	logic [31:0] div_res;

	logic [31:0] w, immi, imms, immb, immj, npc, sum, alu_b, alu_r, ld, svc;
	logic [6:0]  opc;
	logic [4:0]  rd;
	logic [2:0]  f3;
	logic        alt, take, wen;
	logic [31:0] wval;
	logic [32:0] wa, wb;
	logic [65:0] pfull;
	result_t     res;

	rv32_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.sgn(q_head.c.div_signed), .rem(q_head.c.div_rem),
		.a(rf_q[q_head.w.instruction_word[19:15]]),
		.b(rf_q[q_head.w.instruction_word[24:20]]),
		.done(div_done), .result(div_res)
	);

	assign w     = e_q.w.instruction_word;
	assign opc   = w[6:0];
	assign rd    = w[11:7];
	assign f3    = w[14:12];
	assign alt   = w[30];
	assign immi  = {{20{w[31]}}, w[31:20]};
	assign imms  = {{20{w[31]}}, w[31:25], w[11:7]};
	assign immb  = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
	assign immj  = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
	assign svc   = rf_q[17];

	always_comb begin
		alu_b = (opc == OPC_OP) ? b_q :
			((f3 == 3'd1 || f3 == 3'd5) ? {27'd0, w[24:20]} : immi);
		unique case (f3)
			3'd0: alu_r = (opc == OPC_OP && alt) ? a_q - alu_b : a_q + alu_b;
			3'd1: alu_r = a_q << alu_b[4:0];
			3'd2: alu_r = {31'd0, $signed(a_q) < $signed(alu_b)};
			3'd3: alu_r = {31'd0, a_q < alu_b};
			3'd4: alu_r = a_q ^ alu_b;
			3'd5: alu_r = alt ? 32'($signed(a_q) >>> alu_b[4:0]) : a_q >> alu_b[4:0];
			3'd6: alu_r = a_q | alu_b;
			default: alu_r = a_q & alu_b;
		endcase
		unique case (f3)
			3'd0: take = a_q == b_q;
			3'd1: take = a_q != b_q;
			3'd4: take = $signed(a_q) < $signed(b_q);
			3'd5: take = !($signed(a_q) < $signed(b_q));
			3'd6: take = a_q < b_q;
			3'd7: take = a_q >= b_q;
			default: take = 1'b0;
		endcase
		unique case (lkind_q)
			3'd1: ld = {{24{e_q.w.load_value[7]}}, e_q.w.load_value[7:0]};
			3'd2: ld = {{16{e_q.w.load_value[15]}}, e_q.w.load_value[15:0]};
			3'd5: ld = {24'd0, e_q.w.load_value[7:0]};
			3'd6: ld = {16'd0, e_q.w.load_value[15:0]};
			default: ld = e_q.w.load_value;
		endcase
	end

	// signed/unsigned 33x33 product for the high multiplies
	assign wa    = {f3 != 3'd3 && a_q[31], a_q};
	assign wb    = {(f3 == 3'd1) && b_q[31], b_q};
	assign pfull = 66'($signed(wa) * $signed(wb));

	always_comb begin
		res = '0;
		res.retired_count = cnt_q;
		wen  = 1'b0;
		wval = alu_r;
		npc  = pc_q + 32'd4;
		sum  = a_q + immi;
		if (halted_q) begin
			res.console_op = CON_HALT;
		end else if (e_q.w.mode == MODE_LOAD) begin
			if (lkind_q != 3'd0) begin
				wen = 1'b1;
				wval = ld;
			end
		end else if (e_q.w.mode == MODE_CHAR) begin
			if (wcon_q) begin
				wen = 1'b1;
				wval = {{23{e_q.w.console_char[8]}}, e_q.w.console_char};
			end
		end else if (e_q.w.mode == MODE_INSTR && lkind_q == 3'd0 && !wcon_q) begin
			if (w == 32'd0) begin
				res.console_op = CON_HALT;
			end else begin
				res.retired_count = cnt_q + 32'd1;
				unique case (opc)
					OPC_LOAD: begin
						if (f3 != 3'd3 && f3 != 3'd6 && f3 != 3'd7) begin
							res.mem_op = MEM_READ;
							res.mem_size = f3[1:0];
							res.mem_address = sum;
						end
					end
					OPC_STORE: begin
						if (f3 <= 3'd2) begin
							res.mem_op = MEM_WRITE;
							res.mem_size = f3[1:0];
							res.mem_address = a_q + imms;
							res.store_value = f3 == 3'd0 ? {24'd0, b_q[7:0]} :
								f3 == 3'd1 ? {16'd0, b_q[15:0]} : b_q;
						end
					end
					OPC_OPIMM, OPC_OP: begin
						wen = 1'b1;
						if (opc == OPC_OP && w[31:25] == 7'd1) begin
							unique case (f3)
								3'd0: wval = prod_q[31:0];
								3'd1, 3'd2, 3'd3: wval = prod_q[63:32];
								default: wval = div_res;
							endcase
						end
					end
					OPC_LUI: begin
						wen = 1'b1;
						wval = {w[31:12], 12'd0};
					end
					OPC_AUIPC: begin
						wen = 1'b1;
						wval = pc_q + {w[31:12], 12'd0};
					end
					OPC_JAL: begin
						wen = 1'b1;
						wval = npc;
						npc = pc_q + immj;
					end
					OPC_JALR: begin
						wen = 1'b1;
						wval = npc;
						npc = {sum[31:1], 1'b0};
					end
					OPC_BRANCH: begin
						if (take) npc = pc_q + immb;
					end
					OPC_SYSTEM: begin
						if (svc == SVC_GETC) begin
							res.console_op = CON_REQ;
						end else if (svc == SVC_PUTC) begin
							res.console_op = CON_OUT;
							res.console_out = rf_q[16][7:0];
						end else if (svc == SVC_EXIT || svc == SVC_HALT) begin
							res.console_op = CON_HALT;
						end
					end
					default: ;
				endcase
			end
		end
		res.next_pc = npc;
		if (halted_q || e_q.w.mode != MODE_INSTR || lkind_q != 3'd0 || wcon_q ||
				w == 32'd0) begin
			res.next_pc = pc_q;
		end
	end

	assign q_pop     = state_q == ST_IDLE && q_valid && !(out_valid && out_stall);
	assign div_start = q_pop && q_head.c.is_div && !halted_q && lkind_q == 3'd0 && !wcon_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			e_q <= q_head;
			a_q <= rf_q[q_head.w.instruction_word[19:15]];
			b_q <= rf_q[q_head.w.instruction_word[24:20]];
		end
		if (state_q == ST_MUL) prod_q <= pfull[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
			out_res   <= '0;
			pc_q      <= '0;
			cnt_q     <= '0;
			halted_q  <= 1'b0;
			wcon_q    <= 1'b0;
			ldest_q   <= '0;
			lkind_q   <= '0;
			for (int i = 0; i < 32; i++) rf_q[i] <= '0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (cfg_we) pc_q <= cfg_pc;
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= div_start ? ST_DIV :
							(q_head.c.is_mdu ? ST_MUL : ST_EXEC);
					end
				end
				ST_MUL: state_q <= ST_EXEC;
				ST_DIV: if (div_done) state_q <= ST_EXEC;
				default: begin
					state_q   <= ST_IDLE;
					out_valid <= 1'b1;
					out_res   <= res;
					pc_q      <= res.next_pc;
					cnt_q     <= res.retired_count;
					if (wen && ((e_q.w.mode == MODE_LOAD) ? ldest_q != 5'd0 :
							(e_q.w.mode == MODE_CHAR) ? 1'b1 : rd != 5'd0)) begin
						rf_q[(e_q.w.mode == MODE_LOAD) ? ldest_q :
							(e_q.w.mode == MODE_CHAR) ? 5'd17 : rd] <= wval;
					end
					if (res.console_op == CON_HALT) halted_q <= 1'b1;
					if (res.console_op == CON_REQ) wcon_q <= 1'b1;
					if (!halted_q && e_q.w.mode == MODE_CHAR) wcon_q <= 1'b0;
					if (!halted_q && e_q.w.mode == MODE_LOAD) begin
						lkind_q <= '0;
						ldest_q <= '0;
					end
					if (res.mem_op == MEM_READ) begin
						lkind_q <= f3 + 3'd1;
						ldest_q <= rd;
					end
				end
			endcase
		end
	end

endmodule

// ----- rtl/rv32im_instruction_execute.sv -----
// ----------------------------------------------------------------------------
// rv32im_instruction_execute
// RV32IM executor: one result word for each input word.
// ----------------------------------------------------------------------------
// Input channel: mode plus instruction, load data or console character,
// moved by in_valid/in_stall. Output channel: one result word per input
// word, moved by out_valid/out_stall, in order.
// A two-entry queue parts the front end from the execute back end.
// An accepted word passes the queue and the execute registers, and its
// result is registered from ST_EXEC; multiplies first pass ST_MUL, which
// registers the product, and divides and remainders wait in ST_DIV for
// the bit-serial divider. One word is in execution at a time: the next
// word is popped only once the back end is back in ST_IDLE.
// Reset clears registers x0..x31, the pc (to 0), the halt flag and the
// retired count. Writing start_address over APB at offset 0 also loads pc.
// When out_stall is high the result is held and the back end waits; the
// queue keeps taking input until it fills, then in_stall rises.
// ----------------------------------------------------------------------------
module rv32im_instruction_execute import rv32_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [31:0] instruction_word,
	input  logic [31:0] load_value,
	input  logic [8:0]  console_char,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] next_pc,
	output logic [1:0]  mem_op,
	output logic [1:0]  mem_size,
	output logic [31:0] mem_address,
	output logic [31:0] store_value,
	output logic [1:0]  console_op,
	output logic [7:0]  console_out,
	output logic [31:0] retired_count
);

	logic [31:0] start_q;
	logic        cfg_we, q_valid, q_pop;
	qent_t       q_head;
	word_t       in_word;
	result_t     res;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && paddr == 2'd0;
	assign prdata = paddr == 2'd0 ? start_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (cfg_we) begin
			start_q <= pwdata;
		end
	end

	assign in_word = '{mode: mode, instruction_word: instruction_word,
		load_value: load_value, console_char: console_char};

	rv32_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_word(in_word), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
	);

	rv32_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_pc(pwdata),
		.q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
		.out_valid(out_valid), .out_stall(out_stall), .out_res(res)
	);

	assign next_pc       = res.next_pc;
	assign mem_op        = res.mem_op;
	assign mem_size      = res.mem_size;
	assign mem_address   = res.mem_address;
	assign store_value   = res.store_value;
	assign console_op    = res.console_op;
	assign console_out   = res.console_out;
	assign retired_count = res.retired_count;

`ifndef ASSERT_OFF
	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(next_pc))
		else $error("result dropped under stall");
	a_halt_nomem: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && console_op == CON_HALT |-> mem_op == MEM_NONE)
		else $error("memory access while halted");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && mem_op != MEM_NONE |-> retired_count != 32'd0)
		else $error("access without retirement");
`endif

endmodule
